>>> src/sff_pkg.sv
package sff_pkg;

  localparam int HEIGHT_BITS_DEF = 16;
  localparam int POS_BITS        = 12;
  localparam int POS_HALF_BITS   = POS_BITS + 1;
  localparam int OUT_DATA_W      = ((POS_HALF_BITS + 7) / 8) * 8;
  localparam int CFG_INDEX_W     = 2;

  // feature mode codes
  localparam logic [1:0] MODE_EDGE   = 2'd0;
  localparam logic [1:0] MODE_RIDGE  = 2'd1;
  localparam logic [1:0] MODE_VALLEY = 2'd2;
  // spare code, finds nothing
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FEATURE_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RISING_EDGE  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_FORWARD = 2'd3;

  typedef struct packed {
    logic ok;
    logic last;
  } sample_flags_t;

  typedef struct packed {
    logic                     found;
    logic [POS_HALF_BITS-1:0] pos_half;
  } line_result_t;

  // edge lies half a pixel before the sample that completes it
  function automatic logic [POS_HALF_BITS-1:0] edge_pos_half(
    input logic [POS_BITS-1:0] s,
    input logic                fwd
  );
    logic [POS_HALF_BITS-1:0] twice;
    twice = {s, 1'b0};
    if (fwd) begin
      edge_pos_half = (s == '0) ? '0 : twice - POS_HALF_BITS'(1);
    end else begin
      edge_pos_half = twice | POS_HALF_BITS'(1);
    end
  endfunction

endpackage

>>> src/sff_in_stage.sv
module sff_in_stage
  import sff_pkg::*;
#(
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
  parameter int IN_DATA_W   = ((HEIGHT_BITS + POS_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_DATA_W-1:0]          in_tdata,
  input  logic                          in_tuser,
  input  logic                          in_tlast,
  input  logic                          take,
  output logic                          word_valid,
  output logic signed [HEIGHT_BITS-1:0] word_value,
  output logic [POS_BITS-1:0]           word_position,
  output sample_flags_t                 word_flags
);

  logic                          valid_r;
  logic signed [HEIGHT_BITS-1:0] value_r;
  logic [POS_BITS-1:0]           position_r;
  sample_flags_t                 flags_r;
  logic                          load;

  assign in_tready = !valid_r || take;
  assign load      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r       <= in_tdata[HEIGHT_BITS-1:0];
      position_r    <= in_tdata[HEIGHT_BITS +: POS_BITS];
      flags_r.ok    <= in_tuser;
      flags_r.last  <= in_tlast;
    end
  end

  assign word_valid    = valid_r;
  assign word_value    = value_r;
  assign word_position = position_r;
  assign word_flags    = flags_r;

endmodule

>>> src/sff_feature_core.sv
module sff_feature_core
  import sff_pkg::*;
#(
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [HEIGHT_BITS-1:0]        cfg_data,
  input  logic                          step,
  input  logic signed [HEIGHT_BITS-1:0] value,
  input  logic [POS_BITS-1:0]           position,
  input  sample_flags_t                 flags,
  output line_result_t                  result
);

  logic [1:0]                    mode_r;
  logic signed [HEIGHT_BITS-1:0] threshold_r;
  logic                          rising_r;
  logic                          forward_r;

  logic                          prev_usable_r, prev_usable_nxt;
  logic                          prev_above_r, prev_above_nxt;
  logic                          have_r, have_nxt;
  logic signed [HEIGHT_BITS-1:0] best_r, best_nxt;
  logic [POS_HALF_BITS-1:0]      pos_r, pos_nxt;

  logic above;
  logic trans;
  logic better;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_EDGE;
      threshold_r <= '0;
      rising_r    <= 1'b1;
      forward_r   <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FEATURE_MODE: mode_r      <= cfg_data[1:0];
        REG_THRESHOLD:    threshold_r <= cfg_data;
        REG_RISING_EDGE:  rising_r    <= cfg_data[0];
        REG_SCAN_FORWARD: forward_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign above  = value >= threshold_r;
  assign trans  = rising_r ? (!prev_above_r && above) : (prev_above_r && !above);
  assign better = !have_r ||
                  ((mode_r == MODE_RIDGE) ? (value > best_r) : (value < best_r));

  always_comb begin
    prev_usable_nxt = prev_usable_r;
    prev_above_nxt  = prev_above_r;
    have_nxt        = have_r;
    best_nxt        = best_r;
    pos_nxt         = pos_r;
    unique case (mode_r)
      MODE_EDGE: begin
        if (!flags.ok) begin
          prev_usable_nxt = 1'b0;
        end else if (!have_r) begin
          if (prev_usable_r && trans) begin
            pos_nxt  = edge_pos_half(position, forward_r);
            have_nxt = 1'b1;
          end
          prev_above_nxt  = above;
          prev_usable_nxt = 1'b1;
        end
      end
      MODE_RIDGE, MODE_VALLEY: begin
        if (flags.ok && better) begin
          best_nxt = value;
          pos_nxt  = {position, 1'b0};
          have_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result reflects the last sample already folded in
  always_comb begin
    result.found    = have_nxt && (mode_r != MODE_NONE);
    result.pos_half = result.found ? pos_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_usable_r <= 1'b0;
      prev_above_r  <= 1'b0;
      have_r        <= 1'b0;
      best_r        <= '0;
      pos_r         <= '0;
    end else if (step) begin
      if (flags.last) begin
        prev_usable_r <= 1'b0;
        prev_above_r  <= 1'b0;
        have_r        <= 1'b0;
        best_r        <= '0;
        pos_r         <= '0;
      end else begin
        prev_usable_r <= prev_usable_nxt;
        prev_above_r  <= prev_above_nxt;
        have_r        <= have_nxt;
        best_r        <= best_nxt;
        pos_r         <= pos_nxt;
      end
    end
  end

endmodule

>>> src/scanline_feature_finder.sv
// Scan-line feature finder. Height samples of one line stream in, one word per
// cycle unless a last word waits for a full result slot, in scan order; tlast
// marks the final sample. Per register feature_mode the block finds the first
// threshold crossing (edge mode, reported at 2s-1 scanning forward or 2s+1
// backward, in half pixels) or the first strict maximum/minimum (reported at
// 2s). One result word leaves per line, after the last sample. Throughput is one
// sample per cycle under that condition: an input register feeds a single compare
// and update stage whose line state sits in flip-flops, and a result register
// decouples the output. Write configuration only while no line is in flight.
module scanline_feature_finder
  import sff_pkg::*;
#(
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
  parameter int IN_DATA_W   = ((HEIGHT_BITS + POS_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // sample_value, sample_position, zero pad
  input  logic                   in_tuser,   // sample_ok
  input  logic                   in_tlast,   // last_sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // feature_pos_half, zero pad
  output logic                   out_tuser,  // line_found
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [HEIGHT_BITS-1:0] cfg_data
);

  logic                          word_valid;
  logic signed [HEIGHT_BITS-1:0] word_value;
  logic [POS_BITS-1:0]           word_position;
  sample_flags_t                 word_flags;
  line_result_t                  result;
  logic                          take;
  logic                          out_free;

  logic                          out_valid_r;
  line_result_t                  out_result_r;

  // a last word needs the result slot free; other words always advance
  assign out_free = !out_valid_r || out_tready;
  assign take     = word_valid && (!word_flags.last || out_free);

  sff_in_stage #(
    .HEIGHT_BITS (HEIGHT_BITS),
    .IN_DATA_W   (IN_DATA_W)
  ) u_in_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tlast      (in_tlast),
    .take          (take),
    .word_valid    (word_valid),
    .word_value    (word_value),
    .word_position (word_position),
    .word_flags    (word_flags)
  );

  sff_feature_core #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (take),
    .value     (word_value),
    .position  (word_position),
    .flags     (word_flags),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && word_flags.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && word_flags.last) begin
      out_result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_result_r.found;
  assign out_tdata  = OUT_DATA_W'(out_result_r.pos_half);

endmodule
